@@ sv/lof_pkg.sv @@
// Package for the longest ORF finder: base codes, codon codes and the
// character decoder. No dependencies.
`default_nettype none

package lof_pkg;

    typedef logic [1:0] t_base;
    typedef logic [5:0] t_codon;

    typedef struct packed {
        logic  ok;
        t_base code;
    } t_decoded;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_U = 8'h55;

    localparam t_base BASE_A = 2'd0;
    localparam t_base BASE_C = 2'd1;
    localparam t_base BASE_G = 2'd2;
    localparam t_base BASE_U = 2'd3;

    localparam t_codon CODON_AUG = 6'd14;
    localparam t_codon CODON_UAG = 6'd50;
    localparam t_codon CODON_UGA = 6'd56;
    localparam t_codon CODON_UAA = 6'd48;

    localparam logic [2:0] LAST_FRAME = 3'd5;
    localparam logic [2:0] FIRST_FORWARD_FRAME = 3'd3;

    function automatic t_decoded decode_char(input logic [7:0] ch);
        t_decoded d;
        d.ok   = 1'b1;
        d.code = BASE_A;
        case (ch)
            CHAR_A: d.code = BASE_A;
            CHAR_C: d.code = BASE_C;
            CHAR_G: d.code = BASE_G;
            CHAR_T: d.code = BASE_U;
            CHAR_U: d.code = BASE_U;
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic is_stop(input t_codon c);
        return (c == CODON_UAG) || (c == CODON_UGA) || (c == CODON_UAA);
    endfunction

endpackage

`default_nettype wire

@@ sv/longest_orf_finder.sv @@
// Longest open reading frame finder, top level. Stores bases in a
// single-port-read memory and scans six frames from it. Depends on lof_pkg.
`default_nettype none

// Usage: a character word is accepted at a rising edge with i_start high
// and o_busy low. A, C, G, T and U are stored as bases; any other word is
// dropped. Bases beyond MAX_BASES are dropped and flag o_overflow.
// A word with i_last_char high (stored first, if it is a base) starts the
// scan: o_busy stays high while the six frames are read from the base
// memory, one base per cycle through its single read port, three reads per
// codon, and a step between frames to move on. The scan covers all codons
// of the six frames (at most 2 * N for N stored bases); the result strobe
// comes once it ends, and o_busy falls with it.
// The result is presented for one cycle with o_done high: o_found,
// o_frame_index, o_start_codon, o_codon_count (both truncated to 9 bits)
// and o_overflow. The receiver cannot stall, so nothing is held back.
// Loading runs at one word per cycle. Reset clears the base count, the
// overflow flag and the control state; memory contents are not cleared,
// as only entries written for the current sequence are ever read.
// After each result the block starts afresh with an empty sequence.
module longest_orf_finder #(
    parameter int MAX_BASES = 1024
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire  [7:0] i_base_char,
    input  wire        i_last_char,
    output logic       o_busy,
    output logic       o_done,
    output logic       o_found,
    output logic [2:0] o_frame_index,
    output logic [8:0] o_start_codon,
    output logic [8:0] o_codon_count,
    output logic       o_overflow
);
    import lof_pkg::*;

    localparam int AW = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
    localparam int CW = $clog2(MAX_BASES + 1);
    localparam int PW = CW + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;

    // Issue side of the scan.
    logic [2:0]    r_frame;
    logic [1:0]    r_off;
    logic [PW-1:0] r_pos;
    logic [1:0]    r_k;
    logic [CW-1:0] r_cidx;

    // Read pipeline tags, aligned with the memory output.
    logic          r_rd_valid;
    logic [1:0]    r_rd_k;
    logic          r_rd_rev;
    logic          r_rd_first;
    logic [2:0]    r_rd_frame;
    logic [CW-1:0] r_rd_cidx;
    t_base         r_rd_data;

    // Codon evaluation.
    logic [3:0]    r_cod_hi;
    logic          r_open;
    logic [CW-1:0] r_sstart;
    logic [CW-1:0] r_best_len;
    logic [2:0]    r_best_frame;
    logic [CW-1:0] r_best_start;

    logic          r_done;
    logic          r_found;
    logic [2:0]    r_frame_o;
    logic [8:0]    r_start_o;
    logic [8:0]    r_len_o;
    logic          r_ovf_o;

    t_base         mem [MAX_BASES];

    t_decoded      dec;
    logic          accept;
    logic          we;
    logic          codon_avail;
    logic [PW-1:0] fwd_pos;
    logic [PW-1:0] rev_pos;
    logic [AW-1:0] rd_addr;
    t_base         base_now;
    t_codon        codon;
    logic          open_now;
    logic [CW-1:0] orf_len;

    assign dec    = decode_char(i_base_char);
    assign accept = i_start && (r_state == S_IDLE);
    assign we     = accept && dec.ok && (r_count < CW'(MAX_BASES));

    assign codon_avail = (r_pos + PW'(3)) <= PW'(r_count);
    assign fwd_pos     = r_pos + PW'(r_k);
    assign rev_pos     = PW'(r_count) - PW'(1) - fwd_pos;
    assign rd_addr     = (r_frame < FIRST_FORWARD_FRAME) ? rev_pos[AW-1:0] : fwd_pos[AW-1:0];

    assign base_now = r_rd_rev ? ~r_rd_data : r_rd_data;
    assign codon    = {r_cod_hi, base_now};
    assign open_now = r_open && !r_rd_first;
    assign orf_len  = r_rd_cidx - r_sstart + CW'(1);

    // A base written on the last word is read no earlier than the next
    // cycle, so the load and the scan never touch one entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_count[AW-1:0]] <= dec.code;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_open       <= 1'b0;
            r_done       <= 1'b0;
            r_frame      <= '0;
            r_off        <= '0;
            r_pos        <= '0;
            r_k          <= '0;
            r_cidx       <= '0;
            r_sstart     <= '0;
            r_best_len   <= '0;
            r_best_frame <= '0;
            r_best_start <= '0;
        end else begin
            r_done     <= (r_state == S_EMIT);
            r_rd_valid <= (r_state == S_SCAN) && codon_avail;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (dec.ok) begin
                            if (r_count < CW'(MAX_BASES)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (i_last_char) begin
                            r_state      <= S_SCAN;
                            r_frame      <= '0;
                            r_off        <= '0;
                            r_pos        <= '0;
                            r_k          <= '0;
                            r_cidx       <= '0;
                            r_open       <= 1'b0;
                            r_best_len   <= '0;
                            r_best_frame <= '0;
                            r_best_start <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (codon_avail) begin
                        r_rd_k     <= r_k;
                        r_rd_rev   <= r_frame < FIRST_FORWARD_FRAME;
                        r_rd_first <= r_cidx == '0;
                        r_rd_frame <= r_frame;
                        r_rd_cidx  <= r_cidx;
                        if (r_k == 2'd2) begin
                            r_k    <= '0;
                            r_pos  <= r_pos + PW'(3);
                            r_cidx <= r_cidx + CW'(1);
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else if (r_frame == LAST_FRAME) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_frame <= r_frame + 3'd1;
                        r_off   <= (r_off == 2'd2) ? 2'd0 : r_off + 2'd1;
                        r_pos   <= (r_off == 2'd2) ? PW'(0) : PW'(r_off) + PW'(1);
                        r_k     <= '0;
                        r_cidx  <= '0;
                    end
                end
                S_EMIT: begin
                    r_found   <= r_best_len != '0;
                    r_frame_o <= r_best_frame;
                    r_start_o <= 9'(r_best_start);
                    r_len_o   <= 9'(r_best_len);
                    r_ovf_o   <= r_ovf;
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Codon evaluation on the data coming back from the memory.
            if (r_rd_valid) begin
                r_cod_hi <= {r_cod_hi[1:0], base_now};
                if (r_rd_k == 2'd2) begin
                    if (codon == CODON_AUG && !open_now) begin
                        r_open   <= 1'b1;
                        r_sstart <= r_rd_cidx;
                    end else if (is_stop(codon)) begin
                        r_open <= 1'b0;
                        if (open_now && orf_len > r_best_len) begin
                            r_best_len   <= orf_len;
                            r_best_frame <= r_rd_frame;
                            r_best_start <= r_sstart;
                        end
                    end else begin
                        r_open <= open_now;
                    end
                end
            end
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_frame_index = r_frame_o;
    assign o_start_codon = r_start_o;
    assign o_codon_count = r_len_o;
    assign o_overflow    = r_ovf_o;

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_rd_valid)
        else $error("read still in flight when the result is formed");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(r_state == S_SCAN))
        else $error("memory read issued outside the scan");

    a_done_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_EMIT))
        else $error("result strobe without a finished scan");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BASES))
        else $error("base count beyond the store");

    a_none_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_found) |-> (r_len_o == '0 && r_frame_o == '0 && r_start_o == '0))
        else $error("empty result carries a frame or length");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for longest_orf_finder: drives DNA character words,
// predicts the six-frame longest ORF per sequence and checks every result word.
// Depends on lof_pkg and longest_orf_finder.
`timescale 1ns / 100ps

module tb_top;
    import lof_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_CODONS  = 339;

    typedef struct packed {
        logic       found;
        logic [2:0] frame_index;
        logic [8:0] start_codon;
        logic [8:0] codon_count;
        logic       overflow;
    } t_orf_result;

    class orf_scoreboard;
        t_base       base_mem[STORE_DEPTH];
        int          n_bases;
        bit          dropped;
        t_orf_result expected_q[$];
        int          n_errors;
        int          n_chars;
        int          n_results;
        int          n_found;
        int          n_overflow;
        int          longest;

        static function bit stop_codon(t_codon c);
            return (c == CODON_UAG) || (c == CODON_UGA) || (c == CODON_UAA);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit decode_base(logic [7:0] ch, output t_base code);
            code = BASE_A;
            case (ch)
                CHAR_A: code = BASE_A;
                CHAR_C: code = BASE_C;
                CHAR_G: code = BASE_G;
                CHAR_T, CHAR_U: code = BASE_U;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Frames below the first forward one read the reverse complement.
        function t_base strand_base(int frame, int pos);
            if (frame < FIRST_FORWARD_FRAME)
                return t_base'(2'd3 - base_mem[n_bases - 1 - pos]);
            return base_mem[pos];
        endfunction

        function t_orf_result scan_frames();
            t_orf_result r;
            int          frame;
            int          offset;
            int          n_codons;
            int          c;
            int          p;
            int          open_at;
            int          len;
            int          best_len;
            bit          is_open;
            t_codon      cod;
            r = '0;
            best_len = 0;
            for (frame = 0; frame <= LAST_FRAME; frame++) begin
                offset   = frame % 3;
                n_codons = (n_bases > offset) ? (n_bases - offset) / 3 : 0;
                is_open  = 1'b0;
                open_at  = 0;
                for (c = 0; c < n_codons; c++) begin
                    p   = offset + 3 * c;
                    cod = {strand_base(frame, p), strand_base(frame, p + 1),
                           strand_base(frame, p + 2)};
                    if (cod == CODON_AUG && !is_open) begin
                        is_open = 1'b1;
                        open_at = c;
                    end
                    if (stop_codon(cod)) begin
                        if (is_open) begin
                            len = c - open_at + 1;
                            // Strictly longer only, so earlier frames keep ties.
                            if (len > best_len) begin
                                best_len      = len;
                                r.frame_index = 3'(frame);
                                r.start_codon = 9'(open_at);
                            end
                        end
                        is_open = 1'b0;
                    end
                end
            end
            r.found       = (best_len > 0);
            r.codon_count = 9'(best_len);
            r.overflow    = dropped;
            return r;
        endfunction

        function void note_char(logic [7:0] ch, logic last);
            t_base code;
            n_chars++;
            if (decode_base(ch, code)) begin
                if (n_bases < STORE_DEPTH) begin
                    base_mem[n_bases] = code;
                    n_bases++;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (last) begin
                expected_q.push_back(scan_frames());
                n_bases = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_field(string name, logic [8:0] want_v, logic [8:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                n_errors++;
            end
        endfunction

        function void check_result(t_orf_result got);
            t_orf_result want;
            if (expected_q.size() == 0) begin
                $error("result word with no sequence outstanding (count %0d)",
                       got.codon_count);
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            if (want.found) n_found++;
            if (want.overflow) n_overflow++;
            if (want.codon_count > longest) longest = want.codon_count;
            check_field("found", want.found, got.found);
            check_field("frame_index", want.frame_index, got.frame_index);
            check_field("start_codon", want.start_codon, got.start_codon);
            check_field("codon_count", want.codon_count, got.codon_count);
            check_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_start     = 1'b0;
    logic [7:0] i_base_char = 8'h00;
    logic       i_last_char = 1'b0;
    logic       o_busy;
    logic       o_done;
    logic       o_found;
    logic [2:0] o_frame_index;
    logic [8:0] o_start_codon;
    logic [8:0] o_codon_count;
    logic       o_overflow;

    orf_scoreboard sb;
    logic [7:0]    seq_chars[$];
    int            chars_sent;
    int            seqs_sent;

    longest_orf_finder #(
        .MAX_BASES(STORE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_base_char  (i_base_char),
        .i_last_char  (i_last_char),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_frame_index(o_frame_index),
        .o_start_codon(o_start_codon),
        .o_codon_count(o_codon_count),
        .o_overflow   (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Values read here are those the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result('{found: o_found, frame_index: o_frame_index,
                                  start_codon: o_start_codon,
                                  codon_count: o_codon_count, overflow: o_overflow});
            if (i_start && !o_busy)
                sb.note_char(i_base_char, i_last_char);
        end
    end

    function automatic logic [7:0] base_letter(t_base b);
        case (b)
            BASE_A:  return CHAR_A;
            BASE_C:  return CHAR_C;
            BASE_G:  return CHAR_G;
            default: return $urandom_range(1) ? CHAR_T : CHAR_U;
        endcase
    endfunction

    function automatic void push_codon(t_codon cod);
        seq_chars.push_back(base_letter(cod[5:4]));
        seq_chars.push_back(base_letter(cod[3:2]));
        seq_chars.push_back(base_letter(cod[1:0]));
    endfunction

    function automatic t_codon random_stop();
        case ($urandom_range(2))
            0:       return CODON_UAG;
            1:       return CODON_UGA;
            default: return CODON_UAA;
        endcase
    endfunction

    function automatic t_codon random_filler();
        t_codon cod;
        do cod = t_codon'($urandom_range(63));
        while (orf_scoreboard::stop_codon(cod));
        return cod;
    endfunction

    // Codon runs rich in starts and stops, at a random frame offset, on
    // either strand, with the odd dropped word mixed in.
    function automatic void build_coding_seq(int n_codons);
        t_base  b_q[$];
        t_codon cod;
        int     r;
        int     i;
        bit     flip;
        repeat ($urandom_range(2)) b_q.push_back(t_base'($urandom_range(3)));
        repeat (n_codons) begin
            r = $urandom_range(99);
            if (r < 20)      cod = CODON_AUG;
            else if (r < 38) cod = random_stop();
            else             cod = random_filler();
            b_q.push_back(cod[5:4]);
            b_q.push_back(cod[3:2]);
            b_q.push_back(cod[1:0]);
        end
        repeat ($urandom_range(2)) b_q.push_back(t_base'($urandom_range(3)));
        flip = $urandom_range(1);
        for (i = 0; i < b_q.size(); i++) begin
            if ($urandom_range(24) == 0) seq_chars.push_back(8'($urandom_range(255)));
            seq_chars.push_back(base_letter(flip ? t_base'(2'd3 - b_q[b_q.size() - 1 - i])
                                                 : b_q[i]));
        end
    endfunction

    function automatic void build_noise_seq(int n);
        repeat (n) begin
            if ($urandom_range(1)) seq_chars.push_back(base_letter(t_base'($urandom_range(3))));
            else                   seq_chars.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_base_char <= ch;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic send_seq(input int idle_pct);
        int i;
        if (seq_chars.size() == 0) seq_chars.push_back(8'($urandom_range(255)));
        for (i = 0; i < seq_chars.size(); i++)
            send_char(seq_chars[i], i == seq_chars.size() - 1, idle_pct);
        chars_sent += seq_chars.size();
        seqs_sent++;
        seq_chars.delete();
    endtask

    // The first edge lets the monitor note the word taken at the last one.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int idle_pct[3];
        int phase;
        int first_char;
        int first_seq;
        int gap;
        idle_pct = '{0, 81, 18};
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty sequence, a start then a stop, a start inside an open ORF
        // with a partial codon left over, and an ORF that never reaches a stop.
        seq_chars = '{8'h00};
        send_seq(0);
        seq_chars = '{CHAR_A, CHAR_U, CHAR_G, 8'hFF, CHAR_U, CHAR_A, CHAR_A};
        send_seq(0);
        seq_chars = '{CHAR_A, CHAR_T, CHAR_G, CHAR_A, 8'h61, CHAR_U, CHAR_G,
                      CHAR_U, CHAR_G, CHAR_A, CHAR_C};
        send_seq(0);
        seq_chars = '{CHAR_A, CHAR_U, CHAR_G, CHAR_C, CHAR_C, 8'h75, CHAR_C};
        send_seq(0);

        for (phase = 0; phase < 3; phase++) begin
            first_char = chars_sent;
            first_seq  = seqs_sent;
            while (chars_sent - first_char < 60 || seqs_sent - first_seq < 6) begin
                gap = ($urandom_range(3) == 0) ? 0 : idle_pct[phase];
                if ($urandom_range(99) < 70)
                    build_coding_seq(($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(0, 10));
                else
                    build_noise_seq($urandom_range(1, 24));
                send_seq(gap);
            end
            case (phase)
                0: begin
                    // One ORF filling the whole store, then bases beyond it:
                    // widest codon count together with the overflow flag.
                    push_codon(CODON_AUG);
                    repeat (MAX_CODONS) push_codon(random_filler());
                    push_codon(CODON_UAA);
                    seq_chars.push_back(base_letter(BASE_C));
                    repeat ($urandom_range(1, 6))
                        seq_chars.push_back(base_letter(t_base'($urandom_range(3))));
                end
                1: begin
                    // Stops throughout, then a short ORF at the far end.
                    repeat (20) push_codon(CODON_UAA);
                    push_codon(CODON_AUG);
                    push_codon(CODON_UAG);
                    seq_chars.push_back(base_letter(BASE_C));
                end
                default: begin
                    // Loose bases mixed with dropped words.
                    build_noise_seq(24);
                end
            endcase
            send_seq(idle_pct[phase]);
            drain();
        end

        drain();
        repeat (64) @(posedge i_clk);
        $display("Sent %0d character words in %0d sequences, sender idle 0, 81 and 18 %%.",
                 sb.n_chars, seqs_sent);
        $display("Checked %0d results: %0d with an ORF, %0d overflowed, longest %0d codons.",
                 sb.n_results, sb.n_found, sb.n_overflow, sb.longest);
        if (sb.pending() != 0)
            $error("%0d results never arrived", sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("PASS longest_orf_finder");
        else
            $display("FAIL longest_orf_finder");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL longest_orf_finder");
        $finish;
    end

endmodule

@@ files.f @@
sv/lof_pkg.sv
sv/longest_orf_finder.sv
tb/tb_top.sv
